### rtl/core/gspe_pkg.sv
package gspe_pkg;

	localparam int CELL_COUNT    = 1024;
	localparam int MAX_FANIN     = 6;
	localparam int FRACTION_BITS = 16;

	localparam int FB   = FRACTION_BITS;
	localparam int PW   = FRACTION_BITS + 1;
	localparam int IW   = 10;
	localparam int NF   = MAX_FANIN;

	typedef enum logic [3:0] {
		CMD_INPUT    = 4'd0,
		CMD_AND      = 4'd1,
		CMD_OR       = 4'd2,
		CMD_ZERO     = 4'd3,
		CMD_ONE      = 4'd4,
		CMD_BUFFER   = 4'd5,
		CMD_MAJORITY = 4'd6,
		CMD_XOR      = 4'd7,
		CMD_OUTPUT   = 4'd8
	} cmd_code_t;

	localparam logic [1:0] REG_DEFAULT_INPUT_HALF = 2'd0;

	typedef struct packed {
		logic [3:0]    cmd;
		logic [IW-1:0] cell_index;
		logic [2:0]    fanin_count;
		logic [IW-1:0] fanin_a;
		logic [IW-1:0] fanin_b;
		logic [IW-1:0] fanin_c;
		logic [IW-1:0] fanin_d;
		logic [IW-1:0] fanin_e;
		logic [IW-1:0] fanin_f;
		logic [5:0]    invert_mask;
		logic [PW-1:0] input_probability;
	} cell_item_t;

	typedef struct packed {
		logic [IW-1:0] result_index;
		logic [PW-1:0] on_probability;
		logic [FB-1:0] switching_activity;
	} result_item_t;

endpackage

### rtl/core/gspe_ram.sv
module gspe_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/gspe_core.sv
module gspe_core #(
	parameter int CELL_COUNT    = gspe_pkg::CELL_COUNT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  gspe_pkg::cell_item_t  item,
	input  logic                  half_q,
	output logic                  busy,
	output logic                  done,
	output gspe_pkg::result_item_t result
);

	localparam int MAX_FANIN     = gspe_pkg::MAX_FANIN;
	localparam int FRACTION_BITS = gspe_pkg::FRACTION_BITS;
	localparam int AW  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int PW  = FRACTION_BITS + 1;
	localparam int MW  = 2 * PW;
	localparam logic [PW-1:0] ONE = PW'(1) << FRACTION_BITS;
	localparam int KW  = 3;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_WAIT, S_DIST, S_SUM, S_FIN, S_ACT
	} state_t;

	state_t                 state_q;
	gspe_pkg::cell_item_t   it_q;
	logic [2:0]             n_q;
	logic [2:0]             j_q;
	logic [KW-1:0]          k_q;
	logic [PW-1:0]          q_q;
	logic [PW-1:0]          d_q [MAX_FANIN+1];
	logic [PW-1:0]          acc_q;
	logic [PW+1:0]          sum_q;
	logic [PW-1:0]          p_q;
	logic                   done_q;
	logic [FRACTION_BITS-1:0] act_q;

	logic                   we;
	logic [AW-1:0]          raddr;
	logic [PW-1:0]          rdata;
	logic [gspe_pkg::IW-1:0] fidx;
	logic [PW-1:0]          rsat;
	logic [PW-1:0]          qin;
	logic [MW-1:0]          prod1;
	logic [MW-1:0]          prod2;
	logic [MW:0]            dsum;
	logic [2:0]             nsat;
	logic                   kin;
	logic [MW+1:0]          actp;

	gspe_ram #(.WIDTH(PW), .DEPTH(CELL_COUNT)) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(AW'(it_q.cell_index)),
		.wdata(p_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		unique case (j_q)
			3'd0:    fidx = it_q.fanin_a;
			3'd1:    fidx = it_q.fanin_b;
			3'd2:    fidx = it_q.fanin_c;
			3'd3:    fidx = it_q.fanin_d;
			3'd4:    fidx = it_q.fanin_e;
			default: fidx = it_q.fanin_f;
		endcase
	end

	assign raddr = AW'(fidx);
	assign rsat  = (rdata > ONE) ? ONE : rdata;
	assign qin   = it_q.invert_mask[j_q] ? ONE - rsat : rsat;
	assign nsat  = (item.fanin_count > 3'(MAX_FANIN)) ? 3'(MAX_FANIN) : item.fanin_count;
	assign prod1 = MW'(d_q[k_q]) * MW'(ONE - q_q);
	assign prod2 = (k_q == '0) ? '0 : MW'(d_q[k_q - 1'b1]) * MW'(q_q);
	assign dsum  = (MW+1)'(prod1) + (MW+1)'(prod2);
	assign kin   = (it_q.cmd == gspe_pkg::CMD_MAJORITY) ? (k_q > (n_q >> 1)) : k_q[0];
	assign actp  = (MW+2)'(p_q) * (MW+2)'(ONE - p_q);
	assign we    = (state_q == S_FIN);
	assign busy  = (state_q != S_IDLE);
	assign done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_ACT);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						it_q <= item;
						n_q  <= nsat;
						j_q  <= '0;
						acc_q <= ONE;
						for (int i = 0; i <= MAX_FANIN; i++) begin
							d_q[i] <= (i == 0) ? ONE : '0;
						end
						if (item.cmd == gspe_pkg::CMD_BUFFER || item.cmd == gspe_pkg::CMD_OUTPUT) begin
							state_q <= S_READ;
						end else if (item.cmd == gspe_pkg::CMD_AND || item.cmd == gspe_pkg::CMD_OR
							|| item.cmd == gspe_pkg::CMD_MAJORITY || item.cmd == gspe_pkg::CMD_XOR) begin
							state_q <= (nsat == '0) ? S_SUM : S_READ;
							k_q <= '0;
							sum_q <= '0;
						end else begin
							state_q <= S_FIN;
							priority case (item.cmd)
								gspe_pkg::CMD_INPUT: p_q <= half_q ? ONE >> 1 :
									((PW'(item.input_probability) > ONE) ? ONE : PW'(item.input_probability));
								gspe_pkg::CMD_ONE: p_q <= ONE;
								default: p_q <= '0;
							endcase
						end
					end
				end
				S_READ: state_q <= S_WAIT;
				S_WAIT: begin
					priority case (it_q.cmd)
						gspe_pkg::CMD_BUFFER, gspe_pkg::CMD_OUTPUT: begin
							p_q <= qin;
							state_q <= S_FIN;
						end
						gspe_pkg::CMD_AND, gspe_pkg::CMD_OR: begin
							q_q <= (it_q.cmd == gspe_pkg::CMD_OR) ? ONE - qin : qin;
							k_q <= '0;
							state_q <= S_DIST;
						end
						default: begin
							q_q <= qin;
							k_q <= KW'(j_q) + 1'b1;
							state_q <= S_DIST;
						end
					endcase
				end
				S_DIST: begin
					if (it_q.cmd == gspe_pkg::CMD_AND || it_q.cmd == gspe_pkg::CMD_OR) begin
						acc_q <= PW'((MW'(acc_q) * MW'(q_q)) >> FRACTION_BITS);
					end else begin
						d_q[k_q] <= PW'(dsum >> FRACTION_BITS);
						if (k_q != '0) k_q <= k_q - 1'b1;
					end
					if (it_q.cmd == gspe_pkg::CMD_AND || it_q.cmd == gspe_pkg::CMD_OR || k_q == '0) begin
						if (j_q + 1'b1 == n_q) begin
							state_q <= S_SUM;
							k_q <= KW'(1);
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= S_READ;
						end
					end
				end
				S_SUM: begin
					priority case (it_q.cmd)
						gspe_pkg::CMD_AND: begin
							p_q <= acc_q;
							state_q <= S_FIN;
						end
						gspe_pkg::CMD_OR: begin
							p_q <= ONE - acc_q;
							state_q <= S_FIN;
						end
						default: begin
							if (k_q > KW'(n_q)) begin
								p_q <= (sum_q > (PW+2)'(ONE)) ? ONE : PW'(sum_q);
								state_q <= S_FIN;
							end else begin
								if (kin) sum_q <= sum_q + (PW+2)'(d_q[k_q]);
								k_q <= k_q + 1'b1;
							end
						end
					endcase
				end
				S_FIN: begin
					act_q   <= FRACTION_BITS'((actp << 1) >> FRACTION_BITS);
					state_q <= S_ACT;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		result.result_index       = it_q.cell_index;
		result.on_probability     = p_q;
		result.switching_activity = act_q;
	end

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");
	a_p_range: assert property (@(posedge clk) disable iff (!arst_n) done |-> p_q <= ONE)
		else $error("probability above one");
`endif

endmodule

### rtl/core/gate_signal_probability_engine.sv
// Evaluates one netlist cell per accepted item (start high while busy is low). Input, constant
// and other cells are written to the store directly; buffer/output cells read one fanin, and/or
// and majority/xor cells read each of their fanins in turn. Each fanin costs a store read and
// its wait, and each majority/xor fanin j adds j+2 distribution updates, one entry per cycle;
// the final majority/xor sum then visits the distribution entries one at a time. busy is high
// throughout; the result is held for the one cycle that done is high, in which busy is already
// low, and cannot be stalled by the receiver.
module gate_signal_probability_engine #(
	parameter int CELL_COUNT    = gspe_pkg::CELL_COUNT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  gspe_pkg::cell_item_t   item,
	output logic                   busy,
	output logic                   done,
	output gspe_pkg::result_item_t result,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [1:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic half_q;

	assign pready = 1'b1;
	assign prdata = (paddr == gspe_pkg::REG_DEFAULT_INPUT_HALF) ? {31'd0, half_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr == gspe_pkg::REG_DEFAULT_INPUT_HALF) begin
			half_q <= pwdata[0];
		end
	end

	gspe_core #(
		.CELL_COUNT(CELL_COUNT)
	) u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .half_q(half_q),
		.busy(busy), .done(done), .result(result)
	);

endmodule
